// ----- rtl/core/median5_stream_filter_defines.svh -----
// Assertion macros used by the checker file of the median filter.
`ifndef MEDIAN5_STREAM_FILTER_DEFINES_SVH
`define MEDIAN5_STREAM_FILTER_DEFINES_SVH

// Checked on every edge outside reset.
`define MED5_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define MED5_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/med5_pkg.sv -----
package med5_pkg;

    localparam int unsigned WIN_KEEP = 4;
    localparam int unsigned SEEN_W   = 3;
    localparam int unsigned EMIT_W   = 3;

    localparam logic [SEEN_W-1:0] SEEN_MAX    = 3'd7;
    localparam logic [SEEN_W-1:0] SEEN_PASS   = 3'd2;
    localparam logic [SEEN_W-1:0] SEEN_MEDIAN = 3'd4;

    // Bit positions of the pending-result mask, emitted lowest first.
    localparam int unsigned EMIT_MID  = 0;
    localparam int unsigned EMIT_HOLD = 1;
    localparam int unsigned EMIT_NEW  = 2;

    typedef logic [EMIT_W-1:0] emit_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

// ----- rtl/core/med5_cell.sv -----
module med5_cell #(
    parameter int unsigned WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  med5_pkg::cell_ctl_t   ctl,
    input  logic [WIDTH-1:0]      d,
    output logic [WIDTH-1:0]      q
);

    logic [WIDTH-1:0] q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg <= '0;
        end
        else if (ctl.clear)
        begin
            q_reg <= '0;
        end
        else if (ctl.shift)
        begin
            q_reg <= d;
        end
    end

    assign q = q_reg;

endmodule

// ----- rtl/core/med5_cmpx.sv -----
module med5_cmpx #(
    parameter int unsigned WIDTH = 16
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    output logic [WIDTH-1:0] lo,
    output logic [WIDTH-1:0] hi
);

    logic swap;

    assign swap = a > b;
    assign lo   = swap ? b : a;
    assign hi   = swap ? a : b;

endmodule

// ----- rtl/core/median5_stream_filter.sv -----
// Streaming five-tap median filter. One transaction is accepted per clock cycle
// while no pending result stalls the pipeline, and an accepted transaction passes
// through the stage 1 and 2 registers into the result register that drives the port.
// Position p of a sequence is replaced by the median of positions p-2 to p+2, so
// results trail the input by two transactions; the first two and the last two
// positions pass through unchanged. A transaction flagged is_last produces up to
// three results, given one after another from the result register, and holds
// off the input while they drain. The window lives in a chain of four value cells;
// the median is taken by a compare-exchange network split over two pipeline stages.
module median5_stream_filter #(
    parameter int unsigned DATA_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DATA_WIDTH-1:0] delta_in,
    input  logic                  is_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] delta_out,
    output logic                  out_last
);

    logic in_fire;
    logic out_fire;

    // Window cells, entry 0 newest.
    med5_pkg::cell_ctl_t   cell_ctl;
    logic [DATA_WIDTH-1:0] win [med5_pkg::WIN_KEEP];

    logic [med5_pkg::SEEN_W-1:0] seen_reg;
    logic [med5_pkg::SEEN_W-1:0] seen_next;

    med5_pkg::emit_t emit_in;
    logic            use_med_in;

    // Stage 1: raw five values.
    logic                  s1_v_reg;
    logic                  s1_med_reg;
    med5_pkg::emit_t       s1_emit_reg;
    logic [DATA_WIDTH-1:0] s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg, s1_e_reg;

    // Stage 2: one sorted pair and two single values.
    logic                  s2_v_reg;
    logic                  s2_med_reg;
    med5_pkg::emit_t       s2_emit_reg;
    logic [DATA_WIDTH-1:0] s2_p0_reg, s2_p1_reg, s2_s_reg, s2_e_reg;
    logic [DATA_WIDTH-1:0] s2_pass_reg, s2_hold_reg;

    // Stage 3: result register.
    logic                  s3_v_reg;
    med5_pkg::emit_t       s3_emit_reg;
    logic [DATA_WIDTH-1:0] s3_mid_reg, s3_hold_reg, s3_new_reg;

    logic [DATA_WIDTH-1:0] lo_ab, hi_ab, lo_cd, hi_cd;
    logic                  drop_ab;
    logic [DATA_WIDTH-1:0] pair_lo, pair_hi, single;
    logic [DATA_WIDTH-1:0] q0, q1, med, mid_val;

    med5_pkg::emit_t emit_rest;
    logic            s3_done, s3_free, s2_free, s1_free;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    assign cell_ctl = '{shift: in_fire && !is_last, clear: in_fire && is_last};

    genvar gi;
    generate
        for (gi = 0; gi < med5_pkg::WIN_KEEP; gi++)
        begin : g_win
            if (gi == 0)
            begin : g_head
                med5_cell #(.WIDTH(DATA_WIDTH)) u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .ctl   (cell_ctl),
                    .d     (delta_in),
                    .q     (win[gi])
                );
            end
            else
            begin : g_body
                med5_cell #(.WIDTH(DATA_WIDTH)) u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .ctl   (cell_ctl),
                    .d     (win[gi-1]),
                    .q     (win[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        seen_next = seen_reg;
        if (cell_ctl.clear)
        begin
            seen_next = '0;
        end
        else if (cell_ctl.shift && (seen_reg != med5_pkg::SEEN_MAX))
        begin
            seen_next = seen_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    always_comb
    begin
        emit_in                      = '0;
        emit_in[med5_pkg::EMIT_MID]  = seen_reg >= med5_pkg::SEEN_PASS;
        emit_in[med5_pkg::EMIT_HOLD] = is_last && (seen_reg != '0);
        emit_in[med5_pkg::EMIT_NEW]  = is_last;
        use_med_in                   = seen_reg >= med5_pkg::SEEN_MEDIAN;
    end

    // The result register keeps a transaction until every pending result is taken.
    assign emit_rest = s3_emit_reg & (s3_emit_reg - 1'b1);
    assign s3_done   = out_fire && (emit_rest == '0);
    assign s3_free   = !s3_v_reg || s3_done;
    assign s2_free   = !s2_v_reg || s3_free;
    assign s1_free   = !s1_v_reg || s2_free;
    assign in_ready  = s1_free;

    // First half of the median: sort two pairs and drop the smaller of their minima,
    // which cannot be the median.
    med5_cmpx #(.WIDTH(DATA_WIDTH)) u_cx_ab (
        .a  (s1_a_reg),
        .b  (s1_b_reg),
        .lo (lo_ab),
        .hi (hi_ab)
    );

    med5_cmpx #(.WIDTH(DATA_WIDTH)) u_cx_cd (
        .a  (s1_c_reg),
        .b  (s1_d_reg),
        .lo (lo_cd),
        .hi (hi_cd)
    );

    assign drop_ab = lo_ab <= lo_cd;
    assign pair_lo = drop_ab ? lo_cd : lo_ab;
    assign pair_hi = drop_ab ? hi_cd : hi_ab;
    assign single  = drop_ab ? hi_ab : hi_cd;

    // Second half: the median is now the second smallest of the four values left.
    med5_cmpx #(.WIDTH(DATA_WIDTH)) u_cx_se (
        .a  (s2_s_reg),
        .b  (s2_e_reg),
        .lo (q0),
        .hi (q1)
    );

    always_comb
    begin
        if (s2_p0_reg <= q0)
        begin
            med = (s2_p1_reg < q0) ? s2_p1_reg : q0;
        end
        else
        begin
            med = (s2_p0_reg < q1) ? s2_p0_reg : q1;
        end
        mid_val = s2_med_reg ? med : s2_pass_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_v_reg <= in_fire && (emit_in != '0);
            end
            if (s2_free)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_free)
            begin
                s3_v_reg <= s2_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_a_reg    <= win[3];
            s1_b_reg    <= win[2];
            s1_c_reg    <= win[1];
            s1_d_reg    <= win[0];
            s1_e_reg    <= delta_in;
            s1_med_reg  <= use_med_in;
            s1_emit_reg <= emit_in;
        end
        if (s2_free)
        begin
            s2_p0_reg   <= pair_lo;
            s2_p1_reg   <= pair_hi;
            s2_s_reg    <= single;
            s2_e_reg    <= s1_e_reg;
            s2_pass_reg <= s1_c_reg;
            s2_hold_reg <= s1_d_reg;
            s2_med_reg  <= s1_med_reg;
            s2_emit_reg <= s1_emit_reg;
        end
        if (s3_free)
        begin
            s3_mid_reg  <= mid_val;
            s3_hold_reg <= s2_hold_reg;
            s3_new_reg  <= s2_e_reg;
            s3_emit_reg <= s2_emit_reg;
        end
        else if (out_fire)
        begin
            s3_emit_reg <= emit_rest;
        end
    end

    always_comb
    begin
        if (s3_emit_reg[med5_pkg::EMIT_MID])
        begin
            delta_out = s3_mid_reg;
        end
        else if (s3_emit_reg[med5_pkg::EMIT_HOLD])
        begin
            delta_out = s3_hold_reg;
        end
        else
        begin
            delta_out = s3_new_reg;
        end
    end

    assign out_valid = s3_v_reg;
    assign out_last  = !s3_emit_reg[med5_pkg::EMIT_MID] && !s3_emit_reg[med5_pkg::EMIT_HOLD]
                       && s3_emit_reg[med5_pkg::EMIT_NEW];

endmodule

// ----- rtl/core/med5_checker.sv -----
`include "median5_stream_filter_defines.svh"

module med5_checker #(
    parameter int unsigned DATA_WIDTH = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [DATA_WIDTH-1:0] delta_in,
    input logic                  is_last,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [DATA_WIDTH-1:0] delta_out,
    input logic                  out_last
);

    // A stalled result must stay put until it is taken.
    `MED5_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(delta_out) && $stable(out_last), "stalled result changed")

    // With no result waiting, the result register is free and the filter must take input.
    `MED5_ASSERT(a_ready_when_idle, !out_valid |-> in_ready, "input refused while no result pending")

    // A last transaction taken with no result waiting later shows a result on the port.
    `MED5_ASSERT(a_last_latency, in_valid && in_ready && is_last && !out_valid |=> ##2 out_valid, "result of a last transaction missing")

    // Reset leaves no result on the port.
    `MED5_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid, "result valid during reset")

endmodule

bind median5_stream_filter med5_checker #(.DATA_WIDTH(DATA_WIDTH)) u_med5_checker (.*);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned DW           = 16;
    localparam int unsigned NUM_DIR      = 22;
    localparam int unsigned RAND_ITEMS   = 480;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [DW-1:0] value;
        logic          last;
    } result_t;

    typedef enum logic {
        ROW_PREDICT,
        ROW_TYPED
    } row_kind_t;

    typedef enum logic [1:0] {
        VAL_ANY,
        VAL_FEW,
        VAL_PITCH,
        VAL_EXTREME
    } value_style_t;

    // A typed row lists its results in exp0..exp2; only the final one of a
    // row flagged last carries out_last.
    typedef struct packed {
        logic [DW-1:0] value;
        logic          last;
        row_kind_t     kind;
        logic [1:0]    n_exp;
        logic [DW-1:0] exp0;
        logic [DW-1:0] exp1;
        logic [DW-1:0] exp2;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    logic [DW-1:0] delta_in;
    logic          is_last;
    logic          out_valid;
    logic          out_ready;
    logic [DW-1:0] delta_out;
    logic          out_last;

    result_t       filtered_fifo [$];
    logic [DW-1:0] hist [med5_pkg::WIN_KEEP];
    logic [2:0]    seq_count;
    int unsigned   errors = 0;
    int unsigned   idle_cycles = 0;
    bit            in_burst;
    bit            out_burst;
    stim_row_t     dir_rows [NUM_DIR];

    median5_stream_filter #(
        .DATA_WIDTH (DW)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .delta_in  (delta_in),
        .is_last   (is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .delta_out (delta_out),
        .out_last  (out_last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [DW-1:0] median5(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                              input logic [DW-1:0] c, input logic [DW-1:0] d,
                                              input logic [DW-1:0] e);
        logic [DW-1:0] v [5];
        logic [DW-1:0] t;
        int            i;
        int            j;
        v[0] = a;
        v[1] = b;
        v[2] = c;
        v[3] = d;
        v[4] = e;
        for (i = 0; i < 4; i++)
        begin
            for (j = 0; j < 4 - i; j++)
            begin
                if (v[j] > v[j+1])
                begin
                    t      = v[j];
                    v[j]   = v[j+1];
                    v[j+1] = t;
                end
            end
        end
        return v[2];
    endfunction

    // Advances the filter state by one accepted value and returns the results it releases.
    task automatic filter_step(input logic [DW-1:0] x, input logic fin,
                               output result_t res [3], output int n);
        int k;
        n = 0;
        if (seq_count >= med5_pkg::SEEN_PASS)
        begin
            res[n].value = (seq_count >= med5_pkg::SEEN_MEDIAN) ?
                           median5(hist[3], hist[2], hist[1], hist[0], x) : hist[1];
            res[n].last  = 1'b0;
            n++;
        end
        if (fin)
        begin
            if (seq_count != '0)
            begin
                res[n].value = hist[0];
                res[n].last  = 1'b0;
                n++;
            end
            res[n].value = x;
            res[n].last  = 1'b1;
            n++;
            for (k = 0; k < med5_pkg::WIN_KEEP; k++)
                hist[k] = '0;
            seq_count = '0;
        end
        else
        begin
            for (k = med5_pkg::WIN_KEEP - 1; k > 0; k--)
                hist[k] = hist[k-1];
            hist[0] = x;
            if (seq_count != med5_pkg::SEEN_MAX)
                seq_count++;
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(12, 30);
    endfunction

    function automatic logic [DW-1:0] pick_value(input value_style_t style,
                                                 input logic [DW-1:0] base);
        logic [DW-1:0] v;
        case (style)
            VAL_FEW:
                v = base + DW'($urandom_range(0, 3));
            VAL_PITCH:
                // Mostly a steady period with small jitter, now and then a random spike.
                if ($urandom_range(0, 9) == 0)
                    v = DW'($urandom);
                else
                    v = base + DW'($urandom_range(0, 40)) - DW'(20);
            VAL_EXTREME:
                case ($urandom_range(0, 2))
                    0:       v = '0;
                    1:       v = '1;
                    default: v = DW'($urandom);
                endcase
            default:
                v = DW'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_row(input stim_row_t row);
        result_t       res [3];
        logic [DW-1:0] typed_vals [3];
        result_t       r;
        int            n;
        int            k;
        int unsigned   gap;
        gap = in_burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        delta_in <= row.value;
        is_last  <= row.last;
        do @(posedge clk); while (!in_ready);
        filter_step(row.value, row.last, res, n);
        if (row.kind == ROW_TYPED)
        begin
            typed_vals[0] = row.exp0;
            typed_vals[1] = row.exp1;
            typed_vals[2] = row.exp2;
            for (k = 0; k < int'(row.n_exp); k++)
            begin
                r.value = typed_vals[k];
                r.last  = row.last && (k == int'(row.n_exp) - 1);
                filtered_fifo.push_back(r);
            end
        end
        else
        begin
            for (k = 0; k < n; k++)
                filtered_fifo.push_back(res[k]);
        end
    endtask

    task automatic check_result(input logic [DW-1:0] got_v, input logic got_l);
        result_t want;
        if (filtered_fifo.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual delta_out=%h out_last=%b",
                     $time, got_v, got_l);
            errors++;
        end
        else
        begin
            want = filtered_fifo.pop_front();
            if (got_v !== want.value)
            begin
                $display("%0t: delta_out mismatch, expected %h, actual %h",
                         $time, want.value, got_v);
                errors++;
            end
            if (got_l !== want.last)
            begin
                $display("%0t: out_last mismatch, expected %b, actual %b",
                         $time, want.last, got_l);
                errors++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result(delta_out, out_last);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // Output back-pressure: random stalls, with occasional stretches of none at all.
    initial
    begin
        int unsigned stall;
        stall     = 0;
        out_burst = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 299) == 0)
                out_burst = !out_burst;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!out_burst && $urandom_range(0, 2) == 0)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin
        stim_row_t     row;
        value_style_t  style;
        logic [DW-1:0] base;
        int unsigned   sent;
        int unsigned   len;
        int unsigned   k;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        delta_in    = '0;
        is_last     = 1'b0;
        in_burst    = 1'b0;
        seq_count   = '0;
        for (k = 0; k < med5_pkg::WIN_KEEP; k++)
            hist[k] = '0;

        dir_rows = '{
            // Single-value sequence straight after reset.
            '{16'hFFFF, 1'b1, ROW_TYPED,   2'd1, 16'hFFFF, 16'h0000, 16'h0000},
            // Two-value sequence.
            '{16'h0000, 1'b0, ROW_TYPED,   2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h1234, 1'b1, ROW_TYPED,   2'd2, 16'h0000, 16'h1234, 16'h0000},
            // Three values: the last one flushes all three positions.
            '{16'h0001, 1'b0, ROW_TYPED,   2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h0002, 1'b0, ROW_TYPED,   2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h0003, 1'b1, ROW_TYPED,   2'd3, 16'h0001, 16'h0002, 16'h0003},
            // Four values: still too short for any median.
            '{16'hAAAA, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h5555, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h8000, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h7FFF, 1'b1, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            // Long alternating sequence: medians, count saturation, extreme values.
            '{16'hFFFF, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h0000, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'hFFFF, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h0000, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'hFFFF, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h8000, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h0001, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'hFFFE, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h7FFF, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h0000, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h0000, 1'b0, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000},
            '{16'h0000, 1'b1, ROW_PREDICT, 2'd0, 16'h0000, 16'h0000, 16'h0000}
        };

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
            send_row(dir_rows[i]);

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: len = $urandom_range(1, 5);
                9:       len = $urandom_range(31, 80);
                default: len = $urandom_range(6, 30);
            endcase
            style    = value_style_t'($urandom_range(0, 3));
            base     = DW'($urandom);
            in_burst = ($urandom_range(0, 3) == 0);
            for (k = 0; k < len; k++)
            begin
                row       = '0;
                row.value = pick_value(style, base);
                row.last  = (k == len - 1);
                row.kind  = ROW_PREDICT;
                send_row(row);
                sent++;
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (filtered_fifo.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
